@@ rtl/core/kgr_pkg.sv @@
// Shared constants, types and helpers of the k-group reverser.
package kgr_pkg;

  // Group buffer geometry.
  localparam int MAX_GROUP = 16;
  localparam int ADDR_W    = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CNT_W     = ADDR_W + 1;

  // Field and register widths.
  localparam int VAL_W     = 32;
  localparam int GSIZE_W   = 5;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  // Register map and reset value of the group size register.
  localparam logic GSIZE_IDX = 1'b0;
  localparam logic [GSIZE_W-1:0] GSIZE_RESET = GSIZE_W'(2);

  typedef logic signed [VAL_W-1:0] kgr_val_t;
  typedef logic [ADDR_W-1:0]       kgr_addr_t;
  typedef logic [CNT_W-1:0]        kgr_cnt_t;

  // Access request from the sequencer to the group store.
  typedef struct packed {
    logic      we;
    kgr_addr_t waddr;
    kgr_val_t  wdata;
    logic      re;
    kgr_addr_t raddr;
  } kgr_ram_req_t;

  // Group size as used: zero acts as one, large values saturate.
  function automatic kgr_cnt_t kgr_eff_k(input logic [GSIZE_W-1:0] gsize);
    kgr_cnt_t k;
    k = CNT_W'(gsize);
    if (gsize == '0) begin
      k = CNT_W'(1);
    end else if (int'(gsize) > MAX_GROUP) begin
      k = CNT_W'(MAX_GROUP);
    end
    return k;
  endfunction

endpackage

@@ rtl/core/k_group_reverser_top.sv @@
// Top level of the k-group reverser with its configuration register.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    in_value, in_list_end
//   out_     output     out_valid / out_ready  out_value_res, out_run_last, out_list_last
//   cfg_     APB slave  psel, penable, pready  group_size at byte address 0
//
// An item that does not close a group is taken and written to the group store.
// A closing item starts a drain of n results; each is read from the group store into the output
// register, and the next read is issued only once the previous read data has landed there.
// No input transaction is taken during a drain; a stalled output holds the drain at its
// next read. Reset is synchronous and clears the fill count; the group size returns to two.
module k_group_reverser_top
  import kgr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [VAL_W-1:0]  in_value,
  input  logic                     in_list_end,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [VAL_W-1:0]  out_value_res,
  output logic                     out_run_last,
  output logic                     out_list_last,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [APB_AW-1:0]        cfg_paddr,
  input  logic [APB_DW-1:0]        cfg_pwdata,
  output logic [APB_DW-1:0]        cfg_prdata,
  output logic                     cfg_pready
);

  logic [GSIZE_W-1:0] gsize_r;
  logic               cfg_wr;
  logic               cfg_hit;
  kgr_ram_req_t       ram_req;
  kgr_val_t           ram_rd_data;

  // Register decode: the word index sits above the byte offset.
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[APB_AW-1:2] == (APB_AW-2)'(GSIZE_IDX));
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gsize_r <= GSIZE_RESET;
    end else if (cfg_wr && cfg_hit) begin
      gsize_r <= cfg_pwdata[GSIZE_W-1:0];
    end
  end

  assign cfg_prdata = cfg_hit ? APB_DW'(gsize_r) : '0;

  // Sequencer and group store.
  kgr_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .k_eff         (kgr_eff_k(gsize_r)),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .in_list_end   (in_list_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value_res (out_value_res),
    .out_run_last  (out_run_last),
    .out_list_last (out_list_last),
    .ram_req       (ram_req),
    .ram_rd_data   (ram_rd_data)
  );

  kgr_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

endmodule

@@ rtl/core/kgr_ram.sv @@
// Group store: one write port and one read port with registered read data.
module kgr_ram
  import kgr_pkg::*;
(
  input  logic         clk,
  input  kgr_ram_req_t req,
  output kgr_val_t     rd_data
);

  kgr_val_t mem [MAX_GROUP];
  kgr_val_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/kgr_seq.sv @@
// Sequencer: fills the group store and drains completed groups to the output register.
module kgr_seq
  import kgr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  kgr_cnt_t     k_eff,
  input  logic         in_valid,
  output logic         in_ready,
  input  kgr_val_t     in_value,
  input  logic         in_list_end,
  output logic         out_valid,
  input  logic         out_ready,
  output kgr_val_t     out_value_res,
  output logic         out_run_last,
  output logic         out_list_last,
  output kgr_ram_req_t ram_req,
  input  kgr_val_t     ram_rd_data
);

  localparam logic ST_FILL  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic      state_r, state_nxt;
  kgr_addr_t fill_r, fill_nxt;
  kgr_cnt_t  n_r, n_nxt;
  kgr_cnt_t  idx_r, idx_nxt;
  logic      rev_r, rev_nxt;
  logic      end_r, end_nxt;
  logic      rd_pend_r;
  logic      rd_last_r;
  logic      rd_list_r;
  logic      out_valid_r;
  kgr_val_t  out_value_r;
  logic      out_run_last_r;
  logic      out_list_last_r;

  logic      accept;
  kgr_cnt_t  n_in;
  logic      full_grp;
  logic      issue;
  logic      idx_last;
  kgr_cnt_t  rd_idx;

  assign in_ready = (state_r == ST_FILL);
  assign accept   = in_valid && in_ready;
  assign n_in     = CNT_W'(fill_r) + CNT_W'(1);
  assign full_grp = (n_in >= k_eff);

  // A read is issued only when the output register is sure to be free when the data lands.
  assign issue    = (state_r == ST_DRAIN) && !rd_pend_r && (!out_valid_r || out_ready);
  assign idx_last = (idx_r == n_r - CNT_W'(1));
  assign rd_idx   = rev_r ? (n_r - CNT_W'(1) - idx_r) : idx_r;

  // Memory requests: writes while filling, reads while draining.
  always_comb begin
    ram_req.we    = accept;
    ram_req.waddr = fill_r;
    ram_req.wdata = in_value;
    ram_req.re    = issue;
    ram_req.raddr = rd_idx[ADDR_W-1:0];
  end

  // Next-state logic for fill and drain.
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    n_nxt     = n_r;
    idx_nxt   = idx_r;
    rev_nxt   = rev_r;
    end_nxt   = end_r;
    unique case (state_r)
      ST_FILL: begin
        if (accept) begin
          if (full_grp || in_list_end) begin
            state_nxt = ST_DRAIN;
            fill_nxt  = '0;
            n_nxt     = n_in;
            idx_nxt   = '0;
            rev_nxt   = full_grp;
            end_nxt   = in_list_end;
          end else begin
            fill_nxt = n_in[ADDR_W-1:0];
          end
        end
      end
      ST_DRAIN: begin
        if (issue) begin
          idx_nxt = idx_r + CNT_W'(1);
          if (idx_last) begin
            state_nxt = ST_FILL;
          end
        end
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      fill_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      rd_pend_r <= issue;
      if (rd_pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Drain bookkeeping and output payload.
  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    idx_r <= idx_nxt;
    rev_r <= rev_nxt;
    end_r <= end_nxt;
    if (issue) begin
      rd_last_r <= idx_last;
      rd_list_r <= idx_last && end_r;
    end
    if (rd_pend_r) begin
      out_value_r     <= ram_rd_data;
      out_run_last_r  <= rd_last_r;
      out_list_last_r <= rd_list_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_res = out_value_r;
  assign out_run_last  = out_run_last_r;
  assign out_list_last = out_list_last_r;

endmodule

@@ rtl/core/kgr_checker.sv @@
// Port-level checks of the k-group reverser, bound to the top level.
module kgr_checker
  import kgr_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     in_list_end,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [VAL_W-1:0]  out_value_res,
  input logic                     out_run_last,
  input logic                     out_list_last,
  input logic                     cfg_psel,
  input logic                     cfg_penable,
  input logic                     cfg_pwrite,
  input logic [APB_AW-1:0]        cfg_paddr,
  input logic [APB_DW-1:0]        cfg_pwdata,
  input logic [APB_DW-1:0]        cfg_prdata,
  input logic                     cfg_pready
);

  // The end of the list is always the last result of its transaction.
  a_list_last_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_list_last) |-> out_run_last)
    else $error("list_last without run_last");

  // An input marked as list end always starts a drain, so input is held off.
  a_end_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_list_end) |=> !in_ready)
    else $error("input taken straight after a list end");

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value_res)
      && $stable(out_run_last) && $stable(out_list_last)))
    else $error("stalled result changed");

  // A group size write reads back on the next cycle.
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[APB_AW-1:2] == '0)
      |=> (cfg_paddr[APB_AW-1:2] != '0
        || cfg_prdata[GSIZE_W-1:0] == $past(cfg_pwdata[GSIZE_W-1:0])))
    else $error("group size readback mismatch");

endmodule

bind k_group_reverser_top kgr_checker u_kgr_checker (.*);
